>>> rtl/srw_pkg.sv
// Shared package for the selective-repeat receive window.
// Holds request and register codes, reset values and the controller/datapath structs.
// No dependencies.
package srw_pkg;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_FIN     = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic CFG_NACK_GAP     = 1'b1;

  localparam logic [19:0] IDLE_TIMEOUT_RST = 20'd5000;
  localparam logic [15:0] NACK_GAP_RST     = 16'd50;

  typedef struct packed {
    logic capture;
    logic decide;
    logic ins_rd;
    logic ins_wr;
    logic walk_step;
    logic finish;
    logic clr_step;
  } srw_cmd_t;

  typedef struct packed {
    logic need_data;
    logic head_present;
    logic sweep;
    logic clr_last;
    logic out_busy;
  } srw_sts_t;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DEC  = 8'b0000_0100,
    S_IRD  = 8'b0000_1000,
    S_IWR  = 8'b0001_0000,
    S_WRD  = 8'b0010_0000,
    S_WCHK = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } srw_state_t;

endpackage

>>> rtl/srw_ctrl.sv
// Controller state machine of the receive window.
// Sequences decode, slot insert, in-order release walk and clearing sweep; uses srw_pkg.
module srw_ctrl import srw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  srw_sts_t sts,
  output srw_cmd_t cmd
);

  srw_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.need_data ? S_IRD : S_FIN;
      end
      S_IRD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = S_IWR;
      end
      S_IWR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_WRD;
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (sts.head_present) begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_WRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // A result still waiting in the output register holds this one here.
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = sts.sweep ? S_CLR : S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // Reset starts with a sweep that clears every present bit.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/srw_dp.sv
// Datapath of the receive window: session registers, slot memory, result registers.
// Driven by srw_ctrl through srw_cmd_t; uses srw_pkg.
module srw_dp import srw_pkg::*; #(
  parameter int WINDOW_SLOTS   = 4096,
  parameter int MAX_FRAG_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  srw_cmd_t    cmd,
  output srw_sts_t    sts,
  input  logic [1:0]  in_req_type,
  input  logic [47:0] in_peer_id,
  input  logic [31:0] in_seq,
  input  logic [10:0] in_frag_len,
  input  logic [39:0] in_total_size,
  input  logic [31:0] in_now_ms,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_start_ok,
  output logic        out_send_busy,
  output logic        out_ack_valid,
  output logic [31:0] out_ack_seq,
  output logic        out_nack_valid,
  output logic [31:0] out_nack_seq,
  output logic [39:0] out_delivered_bytes,
  output logic        out_session_done,
  output logic        out_idle_expired
);

  localparam int HW   = $clog2(WINDOW_SLOTS);
  localparam int CW   = $clog2(WINDOW_SLOTS + 1);
  localparam int LCAP = (MAX_FRAG_BYTES < 2047) ? MAX_FRAG_BYTES : 2047;
  localparam int LW   = $clog2(LCAP + 1);

  // Captured item.
  logic [1:0]  req_r;
  logic [47:0] peer_r;
  logic [31:0] seq_r, now_r;
  logic [10:0] len_r;
  logic [39:0] total_r;

  // Configuration.
  logic [19:0] timeout_r;
  logic [15:0] gap_r;

  // Session state.
  logic          active_r, active_nxt;
  logic [47:0]   owner_r, owner_nxt;
  logic [31:0]   exp_r, exp_nxt;
  logic [39:0]   bytes_r, bytes_nxt;
  logic [31:0]   last_act_r, last_act_nxt;
  logic [31:0]   last_nack_r, last_nack_nxt;
  logic [HW-1:0] head_r, head_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  logic          sweep_r, sweep_nxt;
  logic [HW-1:0] clr_cnt_r;

  // Per-item decisions.
  logic        res_start_r, res_busy_r, res_exp_r, res_done_r, dat_r;
  logic [39:0] res_done_bytes_r;
  logic [HW-1:0] slot_r;

  // Slot memory: present bit over length.
  logic [LW:0]   mem [WINDOW_SLOTS];
  logic [LW:0]   rd_q_r;
  logic [HW-1:0] rd_addr, wr_addr;
  logic [LW:0]   wr_data;
  logic          wr_en;

  logic          expire, eff_active, foreign, in_window;
  logic          ok_reply_c, busy_c, done_c, touch_c, open_c, data_go_c, clear_c;
  logic [31:0]   seq_off;
  logic [HW:0]   slot_sum;
  logic [HW-1:0] slot_c;
  logic [40:0]   byte_sum;
  logic [10:0]   len_clamp;
  logic          nack_c;

  // Result register.
  logic        ov_r;
  logic        o_start_r, o_busy_r, o_ack_r, o_nack_r, o_done_r, o_exp_r;
  logic [31:0] o_ack_seq_r, o_nack_seq_r;
  logic [39:0] o_bytes_r;

  assign expire     = active_r && (last_act_r != 32'd0) &&
                      ((now_r - last_act_r) > {12'd0, timeout_r});
  assign eff_active = active_r && !expire;
  assign foreign    = peer_r != owner_r;
  assign seq_off    = seq_r - exp_r;
  assign in_window  = (seq_r >= exp_r) && ({1'b0, seq_off} < 33'(WINDOW_SLOTS));
  assign slot_sum   = {1'b0, head_r} + {1'b0, seq_off[HW-1:0]};
  assign slot_c     = (slot_sum >= (HW+1)'(WINDOW_SLOTS)) ?
                      HW'(slot_sum - (HW+1)'(WINDOW_SLOTS)) : slot_sum[HW-1:0];
  assign len_clamp  = ({6'd0, len_r} > 17'(MAX_FRAG_BYTES)) ? 11'(LCAP) : len_r;
  assign byte_sum   = {1'b0, bytes_r} + 41'(rd_q_r[LW-1:0]);
  assign nack_c     = dat_r && (pend_r != '0) && ((now_r - last_nack_r) >= {16'd0, gap_r});

  always_comb begin
    ok_reply_c = 1'b0;
    busy_c     = 1'b0;
    done_c     = 1'b0;
    touch_c    = 1'b0;
    open_c     = 1'b0;
    data_go_c  = 1'b0;
    unique case (req_r)
      REQ_START: begin
        if (eff_active && foreign) begin
          busy_c = 1'b1;
        end else begin
          open_c     = !eff_active;
          ok_reply_c = 1'b1;
          touch_c    = 1'b1;
        end
      end
      REQ_DATA: begin
        if (eff_active) begin
          if (foreign) begin
            busy_c = 1'b1;
          end else begin
            touch_c   = 1'b1;
            data_go_c = in_window;
          end
        end
      end
      REQ_FIN: begin
        if (eff_active) begin
          touch_c = 1'b1;
          if (foreign) busy_c = 1'b1;
          else         done_c = (bytes_r == total_r);
        end
      end
      default: ;
    endcase
  end

  assign clear_c = expire || done_c;

  always_comb begin
    active_nxt    = active_r;
    owner_nxt     = owner_r;
    exp_nxt       = exp_r;
    bytes_nxt     = bytes_r;
    last_act_nxt  = last_act_r;
    last_nack_nxt = last_nack_r;
    head_nxt      = head_r;
    pend_nxt      = pend_r;
    sweep_nxt     = sweep_r;
    if (cmd.decide) begin
      if (clear_c) begin
        active_nxt = 1'b0;
        owner_nxt  = '0;
        exp_nxt    = '0;
        bytes_nxt  = '0;
        head_nxt   = '0;
        pend_nxt   = '0;
        // Stale present bits left in the memory need a sweep.
        sweep_nxt  = pend_r != '0;
      end
      if (open_c) begin
        active_nxt = 1'b1;
        owner_nxt  = peer_r;
      end
      if (touch_c) last_act_nxt = now_r;
    end
    if (cmd.ins_wr && !rd_q_r[LW]) pend_nxt = pend_r + 1'b1;
    if (cmd.walk_step) begin
      bytes_nxt = byte_sum[40] ? '1 : byte_sum[39:0];
      pend_nxt  = pend_r - 1'b1;
      exp_nxt   = exp_r + 32'd1;
      head_nxt  = (head_r == HW'(WINDOW_SLOTS - 1)) ? '0 : head_r + 1'b1;
    end
    if (cmd.finish && nack_c) last_nack_nxt = now_r;
    if (cmd.clr_step && sts.clr_last) sweep_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      owner_r     <= '0;
      exp_r       <= '0;
      bytes_r     <= '0;
      last_act_r  <= '0;
      last_nack_r <= '0;
      head_r      <= '0;
      pend_r      <= '0;
      sweep_r     <= 1'b0;
      clr_cnt_r   <= '0;
      timeout_r   <= IDLE_TIMEOUT_RST;
      gap_r       <= NACK_GAP_RST;
      ov_r        <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      owner_r     <= owner_nxt;
      exp_r       <= exp_nxt;
      bytes_r     <= bytes_nxt;
      last_act_r  <= last_act_nxt;
      last_nack_r <= last_nack_nxt;
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      sweep_r     <= sweep_nxt;
      if (cmd.clr_step) clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDLE_TIMEOUT: timeout_r <= cfg_data;
          CFG_NACK_GAP:     gap_r     <= cfg_data[15:0];
        endcase
      end
      if (cmd.finish)               ov_r <= 1'b1;
      else if (ov_r && !out_stall)  ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      peer_r  <= in_peer_id;
      seq_r   <= in_seq;
      len_r   <= in_frag_len;
      total_r <= in_total_size;
      now_r   <= in_now_ms;
    end
    if (cmd.decide) begin
      res_start_r      <= ok_reply_c;
      res_busy_r       <= busy_c;
      res_exp_r        <= expire;
      res_done_r       <= done_c;
      res_done_bytes_r <= bytes_r;
      dat_r            <= data_go_c;
    end
    if (cmd.ins_rd) slot_r <= slot_c;
    if (cmd.finish) begin
      o_start_r    <= res_start_r;
      o_busy_r     <= res_busy_r;
      o_exp_r      <= res_exp_r;
      o_done_r     <= res_done_r;
      o_ack_r      <= dat_r && (exp_r != 32'd0);
      o_ack_seq_r  <= (dat_r && (exp_r != 32'd0)) ? exp_r - 32'd1 : 32'd0;
      o_nack_r     <= nack_c;
      o_nack_seq_r <= nack_c ? exp_r : 32'd0;
      o_bytes_r    <= res_done_r ? res_done_bytes_r : bytes_r;
    end
  end

  // Memory port selection.
  always_comb begin
    rd_addr = cmd.ins_rd ? slot_c : head_r;
    wr_en   = 1'b0;
    wr_addr = head_r;
    wr_data = '0;
    priority if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (cmd.ins_wr) begin
      wr_en   = !rd_q_r[LW];
      wr_addr = slot_r;
      wr_data = {1'b1, LW'(len_clamp)};
    end else if (cmd.walk_step) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q_r <= mem[rd_addr];
  end

  assign sts.need_data    = data_go_c;
  assign sts.head_present = rd_q_r[LW];
  assign sts.sweep        = sweep_r;
  assign sts.clr_last     = clr_cnt_r == HW'(WINDOW_SLOTS - 1);
  // The output register is free when empty or when its beat is taken this cycle.
  assign sts.out_busy     = ov_r && out_stall;

  assign out_valid           = ov_r;
  assign out_send_start_ok   = o_start_r;
  assign out_send_busy       = o_busy_r;
  assign out_ack_valid       = o_ack_r;
  assign out_ack_seq         = o_ack_seq_r;
  assign out_nack_valid      = o_nack_r;
  assign out_nack_seq        = o_nack_seq_r;
  assign out_delivered_bytes = o_bytes_r;
  assign out_session_done    = o_done_r;
  assign out_idle_expired    = o_exp_r;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CW'(WINDOW_SLOTS))
    else $error("pending count exceeds the window");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (exp_r == 32'd0) && (pend_r == '0) && (head_r == '0))
    else $error("inactive session holds window state");

  a_reply_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $onehot0({o_start_r, o_busy_r, o_done_r}))
    else $error("conflicting replies in one result");

  a_walk_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> dat_r && active_r)
    else $error("release walk outside an accepted data beat");

endmodule

>>> rtl/selective_repeat_receive_window.sv
// Selective-repeat receive window, top level; instantiates srw_ctrl and srw_dp (srw_pkg).
// Steps: start, fin and dropped data pass capture, decide and finish; a data beat in the
//   window adds slot read and write, then a read and a check step per released in-order slot.
// Throughput: one item at a time; the next beat is taken the cycle after the result is loaded
//   unless a sweep follows; a result still waiting holds the next item in its last step.
// Reset: synchronous, then a sweep of all WINDOW_SLOTS slots clears the slot memory; a session
//   cleared with slots still held runs the same sweep before the next beat.
module selective_repeat_receive_window import srw_pkg::*; #(
  parameter int WINDOW_SLOTS   = 4096,
  parameter int MAX_FRAG_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [47:0] in_peer_id,
  input  logic [31:0] in_seq,
  input  logic [10:0] in_frag_len,
  input  logic [39:0] in_total_size,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_start_ok,
  output logic        out_send_busy,
  output logic        out_ack_valid,
  output logic [31:0] out_ack_seq,
  output logic        out_nack_valid,
  output logic [31:0] out_nack_seq,
  output logic [39:0] out_delivered_bytes,
  output logic        out_session_done,
  output logic        out_idle_expired,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  srw_cmd_t cmd;
  srw_sts_t sts;

  assign cfg_ready = 1'b1;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srw_dp #(
    .WINDOW_SLOTS   (WINDOW_SLOTS),
    .MAX_FRAG_BYTES (MAX_FRAG_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_req_type),
    .in_peer_id          (in_peer_id),
    .in_seq              (in_seq),
    .in_frag_len         (in_frag_len),
    .in_total_size       (in_total_size),
    .in_now_ms           (in_now_ms),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_start_ok   (out_send_start_ok),
    .out_send_busy       (out_send_busy),
    .out_ack_valid       (out_ack_valid),
    .out_ack_seq         (out_ack_seq),
    .out_nack_valid      (out_nack_valid),
    .out_nack_seq        (out_nack_seq),
    .out_delivered_bytes (out_delivered_bytes),
    .out_session_done    (out_session_done),
    .out_idle_expired    (out_idle_expired)
  );

endmodule
